// ===== sv/set_associative_write_back_cache_macros.svh =====
// Assertion macros used by the cache back end.
`ifndef SET_ASSOCIATIVE_WRITE_BACK_CACHE_MACROS_SVH
`define SET_ASSOCIATIVE_WRITE_BACK_CACHE_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define SAWB_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define SAWB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SAWB_CHECK(lbl, prop, msg)
`define SAWB_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/sawb_pkg.sv =====
// Shared types, codes and byte helpers of the write-back cache.
package sawb_pkg;

  localparam int ADDR_W    = 27;
  localparam int DATA_W    = 32;
  localparam int WAY_IDX_W = 4;

  localparam logic [1:0] IK_READ  = 2'd0;
  localparam logic [1:0] IK_WRITE = 2'd1;
  localparam logic [1:0] IK_FILL  = 2'd2;
  localparam logic [1:0] IK_BAD   = 2'd3;

  localparam logic [2:0] RK_READ  = 3'd0;
  localparam logic [2:0] RK_WDONE = 3'd1;
  localparam logic [2:0] RK_WB    = 3'd2;
  localparam logic [2:0] RK_FREQ  = 3'd3;
  localparam logic [2:0] RK_WT    = 3'd4;
  localparam logic [2:0] RK_ERR   = 3'd5;

  localparam logic [2:0] WORD_BYTES = 3'd4;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [2:0]        byte_count;
    logic [DATA_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind_res;
    logic [ADDR_W-1:0] address_res;
    logic [DATA_W-1:0] data_res;
    logic [2:0]        byte_count_res;
    logic              last;
  } out_item_t;

  typedef struct packed {
    in_item_t             item;
    logic                 err;
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic [WAY_IDX_W-1:0] victim_way;
    logic                 victim_dirty;
  } cmd_t;

  function automatic logic [31:0] len_mask(input logic [2:0] len);
    logic [31:0] m;
    case (len)
      3'd1: m = 32'h0000_00ff;
      3'd2: m = 32'h0000_ffff;
      3'd3: m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] byte_mask(input logic [2:0] len, input logic [1:0] b);
    logic [7:0] m;
    case (len)
      3'd1: m = 8'h01;
      3'd2: m = 8'h03;
      3'd3: m = 8'h07;
      default: m = 8'h0f;
    endcase
    return m << b;
  endfunction

  // Replace the addressed bytes of a two-word window with write data.
  function automatic logic [63:0] merge64(input logic [63:0] cat, input logic [31:0] d,
                                          input logic [2:0] len, input logic [1:0] b);
    logic [7:0]  m;
    logic [63:0] sd;
    logic [63:0] r;
    m  = byte_mask(len, b);
    sd = {32'h0, d} << {b, 3'b000};
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = m[i] ? sd[8*i +: 8] : cat[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] extract(input logic [63:0] cat, input logic [2:0] len,
                                          input logic [1:0] b);
    logic [63:0] s;
    s = cat >> {b, 3'b000};
    return s[31:0] & len_mask(len);
  endfunction

endpackage

// ===== sv/sawb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sawb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/sawb_front.sv =====
// Front end: accept a beat, look up the set, classify hit, victim and errors.
module sawb_front #(
  parameter int SETS         = 4096,
  parameter int WAYS         = 16,
  parameter int LINE_BYTES   = 64,
  parameter int ADDRESS_BITS = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sawb_pkg::in_item_t  req,
  input  logic                go_ok,
  output logic                look_re,
  output logic [$clog2(SETS)-1:0] look_set,
  input  logic [WAYS*((((ADDRESS_BITS < 27) ? ADDRESS_BITS : 27) - $clog2(LINE_BYTES)
                 - $clog2(SETS) < 1) ? 1 : (((ADDRESS_BITS < 27) ? ADDRESS_BITS : 27)
                 - $clog2(LINE_BYTES) - $clog2(SETS)))-1:0] tag_row,
  input  logic [2*WAYS-1:0]   vd_row,
  input  logic                full,
  output logic                push,
  output sawb_pkg::cmd_t      cmd
);
  import sawb_pkg::*;

  localparam int EA  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int OB  = $clog2(LINE_BYTES);
  localparam int SB  = $clog2(SETS);
  localparam int WB  = $clog2(WAYS);
  localparam int TWR = EA - OB - SB;
  localparam int TW  = (TWR < 1) ? 1 : TWR;
  localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'd1 << EA) - 64'd1);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_LOOK = 2'b10
  } fstate_t;

  fstate_t         state;
  in_item_t        item;
  logic            accept;
  logic [TW-1:0]   tag;
  logic [OB:0]     end_sum;
  logic            hit;
  logic [WB-1:0]   hway;
  logic [WB-1:0]   vway;
  logic [WAYS-1:0] valid_row;
  logic [WAYS-1:0] dirty_row;

  assign req_stall = !((state == F_IDLE) && go_ok);
  assign accept    = req_valid && !req_stall;
  assign look_re   = accept;
  assign look_set  = SB'((req.address & AMASK) >> OB);
  assign push      = (state == F_LOOK) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (accept) state <= F_LOOK;
        F_LOOK: if (push) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{req.kind, req.address & AMASK, req.byte_count, req.data};
    end
  end

  assign valid_row = vd_row[WAYS-1:0];
  assign dirty_row = vd_row[2*WAYS-1:WAYS];
  assign tag       = TW'(item.address >> (OB + SB));
  assign end_sum   = (OB+1)'(item.address[OB-1:0]) + (OB+1)'(item.byte_count);

  always_comb begin
    hit  = 1'b0;
    hway = '0;
    vway = WB'(item.address);
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_row[w]) vway = WB'(w);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (valid_row[w] && (tag_row[w*TW +: TW] == tag)) begin
        hit  = 1'b1;
        hway = WB'(w);
      end
    end
  end

  always_comb begin
    cmd.item         = item;
    cmd.err          = (item.kind == IK_BAD) || (item.byte_count == 3'd0)
                       || (item.byte_count > WORD_BYTES)
                       || (end_sum > (OB+1)'(LINE_BYTES));
    cmd.hit          = hit;
    cmd.hit_way      = WAY_IDX_W'(hway);
    cmd.victim_way   = WAY_IDX_W'(vway);
    cmd.victim_dirty = valid_row[vway] && dirty_row[vway];
  end
endmodule

// ===== sv/sawb_queue.sv =====
// Two-entry command queue between the front and back ends.
module sawb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sawb_pkg::cmd_t din,
  input  logic           pop,
  output sawb_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import sawb_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= !wptr;
      if (pop && !empty) rptr <= !rptr;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= din;
  end
endmodule

// ===== sv/sawb_back.sv =====
// Back end: hits, misses, writeback, fills, result register and clearing pass.
`include "set_associative_write_back_cache_macros.svh"
module sawb_back #(
  parameter int SETS         = 4096,
  parameter int WAYS         = 16,
  parameter int LINE_BYTES   = 64,
  parameter int ADDRESS_BITS = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                pop,
  input  sawb_pkg::cmd_t      cmd,
  input  logic [WAYS*((((ADDRESS_BITS < 27) ? ADDRESS_BITS : 27) - $clog2(LINE_BYTES)
                 - $clog2(SETS) < 1) ? 1 : (((ADDRESS_BITS < 27) ? ADDRESS_BITS : 27)
                 - $clog2(LINE_BYTES) - $clog2(SETS)))-1:0] tag_row,
  input  logic [2*WAYS-1:0]   vd_row,
  output logic                tag_we,
  output logic [$clog2(SETS)-1:0] tag_waddr,
  output logic [WAYS*((((ADDRESS_BITS < 27) ? ADDRESS_BITS : 27) - $clog2(LINE_BYTES)
                 - $clog2(SETS) < 1) ? 1 : (((ADDRESS_BITS < 27) ? ADDRESS_BITS : 27)
                 - $clog2(LINE_BYTES) - $clog2(SETS)))-1:0] tag_wdata,
  output logic                vd_we,
  output logic [$clog2(SETS)-1:0] vd_waddr,
  output logic [2*WAYS-1:0]   vd_wdata,
  output logic                d_we,
  output logic [$clog2(SETS)+$clog2(WAYS)+$clog2(LINE_BYTES/4)-1:0] d_waddr,
  output logic [31:0]         d_wdata,
  output logic                d_re,
  output logic [$clog2(SETS)+$clog2(WAYS)+$clog2(LINE_BYTES/4)-1:0] d_raddr,
  input  logic [31:0]         d_rdata,
  output logic                idle,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sawb_pkg::out_item_t rsp
);
  import sawb_pkg::*;

  localparam int EA  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int OB  = $clog2(LINE_BYTES);
  localparam int SB  = $clog2(SETS);
  localparam int WB  = $clog2(WAYS);
  localparam int WWB = $clog2(LINE_BYTES / 4);
  localparam int SLB = SB + WB;
  localparam int TWR = EA - OB - SB;
  localparam int TW  = (TWR < 1) ? 1 : TWR;
  localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'd1 << EA) - 64'd1);
  localparam logic [ADDR_W-1:0] LMASK = ADDR_W'(LINE_BYTES - 1);

  typedef enum logic [12:0] {
    B_CLEAR  = 13'b0000000000001,
    B_IDLE   = 13'b0000000000010,
    B_EXEC   = 13'b0000000000100,
    B_RD0    = 13'b0000000001000,
    B_RD1    = 13'b0000000010000,
    B_HIT    = 13'b0000000100000,
    B_WR1    = 13'b0000001000000,
    B_WT     = 13'b0000010000000,
    B_WB_RD  = 13'b0000100000000,
    B_WB_OUT = 13'b0001000000000,
    B_FREQ   = 13'b0010000000000,
    B_RESP   = 13'b0100000000000,
    B_FEND   = 13'b1000000000000
  } bstate_t;

  bstate_t          state;
  cmd_t             cur;
  logic [SB-1:0]    clr;
  logic             pending;
  logic [SLB-1:0]   pslot;
  logic [ADDR_W-1:0] paddr;
  logic             pwrite;
  logic [31:0]      pdata;
  logic [2:0]       plen;
  logic [WWB-1:0]   pcnt;
  logic [WAYS*TW-1:0] prow_tag;
  logic [2*WAYS-1:0]  prow_vd;
  logic [TW-1:0]    vtag;
  logic [31:0]      lo;
  logic [31:0]      hi;
  logic [WWB-1:0]   wbc;
  out_item_t        res;

  logic             out_free;
  logic             emit;
  logic [ADDR_W-1:0] caddr;
  logic [1:0]       cb;
  logic [WWB-1:0]   cw0;
  logic [WWB-1:0]   cw1;
  logic [SB-1:0]    cset;
  logic [WB-1:0]    hway;
  logic [WB-1:0]    vway;
  logic             cspan;
  logic [1:0]       pb;
  logic [WWB-1:0]   pw0;
  logic [WWB-1:0]   pw1;
  logic             pspan;
  logic [SB-1:0]    pset;
  logic [WB-1:0]    pway;
  logic [TW-1:0]    ptag;
  logic [63:0]      hm;
  logic [63:0]      mlo;
  logic [63:0]      mhi;
  logic [31:0]      fill_word;
  logic [WAYS-1:0]  rv;
  logic [WAYS-1:0]  rdirty;
  logic [WAYS-1:0]  pv;
  logic [WAYS-1:0]  pdirty;
  logic [ADDR_W-1:0] wb_addr;
  logic             is_fill;
  logic             is_err;

  assign out_free = !rsp_valid || !rsp_stall;
  assign emit     = out_free && ((state == B_WT) || (state == B_WB_OUT)
                                 || (state == B_FREQ) || (state == B_RESP));
  assign idle     = (state == B_IDLE);
  assign pop      = (state == B_IDLE) && !q_empty;

  assign caddr = cur.item.address;
  assign cb    = caddr[1:0];
  assign cw0   = caddr[OB-1:2];
  assign cw1   = cw0 + WWB'(1);
  assign cset  = SB'(caddr >> OB);
  assign hway  = WB'(cur.hit_way);
  assign vway  = WB'(cur.victim_way);
  assign cspan = ({2'b00, cb} + {1'b0, cur.item.byte_count}) > {1'b0, WORD_BYTES};

  assign pb    = paddr[1:0];
  assign pw0   = paddr[OB-1:2];
  assign pw1   = pw0 + WWB'(1);
  assign pspan = ({2'b00, pb} + {1'b0, plen}) > {1'b0, WORD_BYTES};
  assign pset  = pslot[SLB-1:WB];
  assign pway  = pslot[WB-1:0];
  assign ptag  = TW'(paddr >> (OB + SB));

  assign hm  = merge64({hi, lo}, cur.item.data, cur.item.byte_count, cb);
  assign mlo = merge64({32'h0, cur.item.data}, pdata, plen, pb);
  assign mhi = merge64({cur.item.data, 32'h0}, pdata, plen, pb);

  always_comb begin
    if (pwrite && (pcnt == pw0)) begin
      fill_word = mlo[31:0];
    end else if (pwrite && pspan && (pcnt == pw1)) begin
      fill_word = mhi[63:32];
    end else begin
      fill_word = cur.item.data;
    end
  end

  assign rv      = vd_row[WAYS-1:0];
  assign rdirty  = vd_row[2*WAYS-1:WAYS];
  assign pv      = prow_vd[WAYS-1:0];
  assign pdirty  = prow_vd[2*WAYS-1:WAYS];
  assign wb_addr = ADDR_W'((64'(vtag) << (OB + SB)) | (64'(cset) << OB) | (64'(wbc) << 2))
                   & AMASK;
  assign is_fill = (cur.item.kind == IK_FILL);
  assign is_err  = cur.err || pending;

  // Memory port steering.
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = pset;
    for (int w = 0; w < WAYS; w++) begin
      tag_wdata[w*TW +: TW] = (WB'(w) == pway) ? ptag : prow_tag[w*TW +: TW];
    end
    vd_we    = 1'b0;
    vd_waddr = cset;
    vd_wdata = vd_row;
    d_we     = 1'b0;
    d_waddr  = {cset, hway, cw0};
    d_wdata  = hm[31:0];
    d_re     = 1'b0;
    d_raddr  = {cset, hway, cw0};
    case (state)
      B_CLEAR: begin
        vd_we    = 1'b1;
        vd_waddr = clr;
        vd_wdata = '0;
      end
      B_EXEC: begin
        if (is_fill) begin
          d_we    = pending;
          d_waddr = {pslot, pcnt};
          d_wdata = fill_word;
        end else if (!is_err && cur.hit) begin
          d_re = 1'b1;
        end else if (!is_err) begin
          vd_we    = 1'b1;
          vd_wdata = {rdirty & ~(WAYS'(1) << vway), rv & ~(WAYS'(1) << vway)};
        end
      end
      B_RD0: begin
        d_re    = 1'b1;
        d_raddr = {cset, hway, cw1};
      end
      B_HIT: begin
        if (cur.item.kind == IK_WRITE) begin
          d_we     = 1'b1;
          vd_we    = 1'b1;
          vd_wdata = {rdirty | (WAYS'(1) << hway), rv};
        end
      end
      B_WR1: begin
        d_we    = 1'b1;
        d_waddr = {cset, hway, cw1};
        d_wdata = hm[63:32];
      end
      B_WB_RD: begin
        d_re    = 1'b1;
        d_raddr = {cset, vway, wbc};
      end
      B_FEND: begin
        tag_we   = 1'b1;
        vd_we    = 1'b1;
        vd_waddr = pset;
        vd_wdata = {pwrite ? (pdirty | (WAYS'(1) << pway)) : (pdirty & ~(WAYS'(1) << pway)),
                    pv | (WAYS'(1) << pway)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      pending   <= 1'b0;
      pcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_free) rsp_valid <= emit;
      case (state)
        B_CLEAR: begin
          clr <= clr + SB'(1);
          if (clr == SB'(SETS - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty) state <= B_EXEC;
        end
        B_EXEC: begin
          if (is_fill) begin
            if (!pending) begin
              state <= B_IDLE;
            end else begin
              pcnt <= pcnt + WWB'(1);
              if (pcnt == WWB'(LINE_BYTES / 4 - 1)) begin
                pending <= 1'b0;
                state   <= B_FEND;
              end else begin
                state <= B_IDLE;
              end
            end
          end else if (is_err) begin
            state <= B_RESP;
          end else if (cur.hit) begin
            state <= B_RD0;
          end else begin
            pending <= 1'b1;
            pcnt    <= '0;
            wbc     <= '0;
            if (cur.item.kind == IK_WRITE) begin
              state <= B_WT;
            end else if (cur.victim_dirty) begin
              state <= B_WB_RD;
            end else begin
              state <= B_FREQ;
            end
          end
        end
        B_RD0:  state <= B_RD1;
        B_RD1:  state <= B_HIT;
        B_HIT: begin
          if ((cur.item.kind == IK_WRITE) && cspan) state <= B_WR1;
          else state <= B_RESP;
        end
        B_WR1:  state <= B_RESP;
        B_WT: begin
          if (out_free) begin
            state <= cur.victim_dirty ? B_WB_RD : B_FREQ;
          end
        end
        B_WB_RD: state <= B_WB_OUT;
        B_WB_OUT: begin
          if (out_free) begin
            wbc   <= wbc + WWB'(1);
            state <= (wbc == WWB'(LINE_BYTES / 4 - 1)) ? B_FREQ : B_WB_RD;
          end
        end
        B_FREQ: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        B_RESP: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        B_FEND: state <= B_RESP;
        default: state <= B_IDLE;
      endcase
    end
  end

  // Payload registers: command, miss record, captured words, result.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) cur <= cmd;
      end
      B_EXEC: begin
        if (is_fill) begin
          if (pcnt == pw0) lo <= cur.item.data;
          if (pcnt == pw1) hi <= cur.item.data;
        end else if (is_err) begin
          res <= '{RK_ERR, caddr, 32'h0, 3'd0, 1'b1};
        end else if (!cur.hit) begin
          pslot    <= {cset, vway};
          paddr    <= caddr;
          pwrite   <= (cur.item.kind == IK_WRITE);
          pdata    <= cur.item.data;
          plen     <= cur.item.byte_count;
          prow_tag <= tag_row;
          prow_vd  <= {rdirty & ~(WAYS'(1) << vway), rv & ~(WAYS'(1) << vway)};
          vtag     <= tag_row[vway*TW +: TW];
        end
      end
      B_RD0: lo <= d_rdata;
      B_RD1: hi <= d_rdata;
      B_HIT: begin
        if (cur.item.kind == IK_WRITE) begin
          res <= '{RK_WDONE, caddr, 32'h0, cur.item.byte_count, 1'b1};
        end else begin
          res <= '{RK_READ, caddr, extract({hi, lo}, cur.item.byte_count, cb),
                   cur.item.byte_count, 1'b1};
        end
      end
      B_FEND: begin
        if (pwrite) begin
          res <= '{RK_WDONE, paddr, 32'h0, plen, 1'b1};
        end else begin
          res <= '{RK_READ, paddr, extract({hi, lo}, plen, pb), plen, 1'b1};
        end
      end
      default: begin
      end
    endcase
    if (out_free) begin
      case (state)
        B_WT:     rsp <= '{RK_WT, caddr, cur.item.data & len_mask(cur.item.byte_count),
                           cur.item.byte_count, 1'b0};
        B_WB_OUT: rsp <= '{RK_WB, wb_addr, d_rdata, WORD_BYTES, 1'b0};
        B_FREQ:   rsp <= '{RK_FREQ, caddr & ~LMASK, 32'h0, 3'd0, 1'b1};
        B_RESP:   rsp <= res;
        default: begin
        end
      endcase
    end
  end

  `SAWB_NEVER(a_cnt_pending, (pcnt != '0) && !pending, "fill count moved with no miss open")
  `SAWB_CHECK(a_hit_path, (state == B_RD0) |-> (cur.hit && !is_fill), "hit path without hit")
  `SAWB_CHECK(a_wb_dirty, (state == B_WB_RD) |-> (cur.victim_dirty && pending), "clean writeback")
  `SAWB_NEVER(a_clear_pending, (state == B_CLEAR) && pending, "miss open during clearing pass")
endmodule

// ===== sv/set_associative_write_back_cache.sv =====
// Top level of the set-associative write-back, write-allocate cache.
// Usage: SETS sets of WAYS ways, LINE_BYTES per line, byte addresses masked to
// ADDRESS_BITS. Beats on req carry cpu reads, cpu writes and fill words; every
// result leaves on rsp, the final one of a request marked by last. After reset
// the block clears its valid and dirty rows, one set per cycle, so it takes no
// request until that pass is done. A request then passes the front end (accept,
// then tag and state lookup with registered read) and is queued for the back
// end. The back end handles an error, a dropped or non-final fill word, the
// final fill word of a line, a read hit (two data reads) and a write hit (two
// data reads, then one or two data writes); a miss takes a step for each
// writeback word and each result beat, and a stall on rsp holds a result beat.
// The next request is taken once the back end is idle, so the data memory
// read/modify/write sets the pace; a finished result may still wait in the
// output register while the next request is taken.
module set_associative_write_back_cache #(
  parameter int SETS         = 4096,
  parameter int WAYS         = 16,
  parameter int LINE_BYTES   = 64,
  parameter int ADDRESS_BITS = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sawb_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sawb_pkg::out_item_t rsp
);
  import sawb_pkg::*;

  localparam int EA  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int OB  = $clog2(LINE_BYTES);
  localparam int SB  = $clog2(SETS);
  localparam int WB  = $clog2(WAYS);
  localparam int WWB = $clog2(LINE_BYTES / 4);
  localparam int TWR = EA - OB - SB;
  localparam int TW  = (TWR < 1) ? 1 : TWR;
  localparam int DAB = SB + WB + WWB;

  // Front to back command path.
  cmd_t q_in;
  cmd_t q_head;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  logic back_idle;

  // Tag and valid/dirty rows: front reads, back writes.
  logic               look_re;
  logic [SB-1:0]      look_set;
  logic [WAYS*TW-1:0] tag_row;
  logic [2*WAYS-1:0]  vd_row;
  logic               tag_we;
  logic [SB-1:0]      tag_waddr;
  logic [WAYS*TW-1:0] tag_wdata;
  logic               vd_we;
  logic [SB-1:0]      vd_waddr;
  logic [2*WAYS-1:0]  vd_wdata;

  // Line data: back end only.
  logic           d_we;
  logic [DAB-1:0] d_waddr;
  logic [31:0]    d_wdata;
  logic           d_re;
  logic [DAB-1:0] d_raddr;
  logic [31:0]    d_rdata;

  sawb_front #(
    .SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .go_ok    (back_idle && q_empty),
    .look_re  (look_re),
    .look_set (look_set),
    .tag_row  (tag_row),
    .vd_row   (vd_row),
    .full     (q_full),
    .push     (q_push),
    .cmd      (q_in)
  );

  sawb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .pop  (q_pop),
    .head (q_head),
    .empty(q_empty),
    .full (q_full)
  );

  sawb_back #(
    .SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop      (q_pop),
    .cmd      (q_head),
    .tag_row  (tag_row),
    .vd_row   (vd_row),
    .tag_we   (tag_we),
    .tag_waddr(tag_waddr),
    .tag_wdata(tag_wdata),
    .vd_we    (vd_we),
    .vd_waddr (vd_waddr),
    .vd_wdata (vd_wdata),
    .d_we     (d_we),
    .d_waddr  (d_waddr),
    .d_wdata  (d_wdata),
    .d_re     (d_re),
    .d_raddr  (d_raddr),
    .d_rdata  (d_rdata),
    .idle     (back_idle),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // One row of tags per set, so all ways compare in one lookup.
  sawb_ram #(.WIDTH(WAYS*TW), .DEPTH(SETS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .re(look_re), .raddr(look_set), .rdata(tag_row)
  );

  // Valid and dirty bits of a set side by side; cleared by the sweep after reset.
  sawb_ram #(.WIDTH(2*WAYS), .DEPTH(SETS)) u_vd_ram (
    .clk(clk), .we(vd_we), .waddr(vd_waddr), .wdata(vd_wdata),
    .re(look_re), .raddr(look_set), .rdata(vd_row)
  );

  // Line words addressed by set, way and word.
  sawb_ram #(.WIDTH(32), .DEPTH(SETS*WAYS*(LINE_BYTES/4))) u_data_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );
endmodule

// ===== sim/cache_checker.sv =====
// Predicts cache results from the request channel and compares them on the result channel.
module cache_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  sawb_pkg::in_item_t  req,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  sawb_pkg::out_item_t rsp,
  output int                  mismatches,
  output int                  pending_results,
  output int                  results_seen
);
  import sawb_pkg::*;

  localparam int NSETS = 4096;
  localparam int NWAYS = 16;
  localparam int LBYTES = 64;
  localparam int LWORDS = 16;

  logic [8:0]  line_tag [int];
  bit          line_valid [int];
  bit          line_dirty [int];
  logic [31:0] line_data [int];

  bit          miss_open;
  int          miss_slot;
  logic [26:0] miss_addr;
  bit          miss_write;
  logic [31:0] miss_wdata;
  logic [2:0]  miss_len;
  int          fill_index;

  out_item_t   expected_results[$];

  function automatic out_item_t mk(logic [2:0] k, logic [26:0] a, logic [31:0] d,
                                   logic [2:0] c);
    out_item_t r;
    r.kind_res = k; r.address_res = a; r.data_res = d; r.byte_count_res = c;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic bit slot_valid(int s);
    return line_valid.exists(s) && line_valid[s];
  endfunction

  function automatic logic [31:0] mask_of(logic [2:0] len);
    return (len >= 4) ? 32'hffff_ffff : ((32'h1 << (8 * len)) - 1);
  endfunction

  function automatic logic [31:0] fetch_bytes(int s, int off, int len);
    logic [31:0] v;
    int o;
    v = 0;
    for (int i = 0; i < len; i++) begin
      o = off + i;
      v |= ((line_data[s * LWORDS + o / 4] >> (8 * (o % 4))) & 32'hff) << (8 * i);
    end
    return v;
  endfunction

  task automatic store_bytes(int s, int off, int len, logic [31:0] d);
    int o;
    int wi;
    for (int i = 0; i < len; i++) begin
      o = off + i;
      wi = s * LWORDS + o / 4;
      line_data[wi][8 * (o % 4) +: 8] = d[8 * i +: 8];
    end
    line_dirty[s] = 1;
  endtask

  task automatic predict_access(in_item_t it);
    out_item_t r;
    out_item_t batch[$];
    int off, set, tag, base, slot, len;
    bit hit;
    logic [26:0] vb;
    off = it.address % LBYTES;
    len = it.byte_count;
    if (it.kind == IK_FILL) begin
      if (!miss_open) return;
      line_data[miss_slot * LWORDS + fill_index] = it.data;
      fill_index++;
      if (fill_index < LWORDS) return;
      off = miss_addr % LBYTES;
      line_tag[miss_slot] = 9'(miss_addr / (LBYTES * NSETS));
      line_valid[miss_slot] = 1;
      line_dirty[miss_slot] = 0;
      miss_open = 0;
      fill_index = 0;
      if (miss_write) begin
        store_bytes(miss_slot, off, miss_len, miss_wdata);
        r = mk(RK_WDONE, miss_addr, 32'h0, miss_len);
      end else begin
        r = mk(RK_READ, miss_addr, fetch_bytes(miss_slot, off, miss_len), miss_len);
      end
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    if (it.kind == IK_BAD || miss_open || len == 0 || len > 4 || off + len > LBYTES) begin
      r = mk(RK_ERR, it.address, 32'h0, 3'd0);
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    set = (it.address / LBYTES) % NSETS;
    tag = it.address / (LBYTES * NSETS);
    base = set * NWAYS;
    hit = 0;
    for (int w = 0; w < NWAYS && !hit; w++) begin
      slot = base + w;
      if (slot_valid(slot) && line_tag[slot] == tag) hit = 1;
    end
    if (hit) begin
      if (it.kind == IK_WRITE) begin
        store_bytes(slot, off, len, it.data);
        r = mk(RK_WDONE, it.address, 32'h0, 3'(len));
      end else begin
        r = mk(RK_READ, it.address, fetch_bytes(slot, off, len), 3'(len));
      end
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    slot = base + (it.address % NWAYS);
    for (int w = NWAYS - 1; w >= 0; w--)
      if (!slot_valid(base + w)) slot = base + w;
    if (it.kind == IK_WRITE)
      batch.push_back(mk(RK_WT, it.address, it.data & mask_of(3'(len)), 3'(len)));
    if (slot_valid(slot) && line_dirty[slot]) begin
      vb = 27'((line_tag[slot] * NSETS + set) * LBYTES);
      for (int w = 0; w < LWORDS; w++)
        batch.push_back(mk(RK_WB, 27'(vb + 4 * w), line_data[slot * LWORDS + w],
                           WORD_BYTES));
    end
    batch.push_back(mk(RK_FREQ, 27'(it.address - off), 32'h0, 3'd0));
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
    line_valid[slot] = 0;
    line_dirty[slot] = 0;
    miss_open = 1;
    miss_slot = slot;
    miss_addr = it.address;
    miss_write = (it.kind == IK_WRITE);
    miss_wdata = it.data;
    miss_len = it.byte_count;
    fill_index = 0;
  endtask

  task automatic report_mismatch(string what, out_item_t got, out_item_t want);
    $display("mismatch %0s: got k%0d a%h d%h c%0d l%0d, want k%0d a%h d%h c%0d l%0d",
             what, got.kind_res, got.address_res, got.data_res, got.byte_count_res,
             got.last, want.kind_res, want.address_res, want.data_res,
             want.byte_count_res, want.last);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    results_seen = 0;
    pending_results = 0;
    miss_open = 0;
    fill_index = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (req_valid && !req_stall) predict_access(req);
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", rsp, rsp);
        end else begin
          want = expected_results.pop_front();
          if (rsp !== want) report_mismatch("field", rsp, want);
        end
      end
    end
    pending_results = expected_results.size();
  end
endmodule

// ===== sim/tb_top.sv =====
// Stimulus and verdict for the write-back cache testbench.
module tb_top;
  import sawb_pkg::*;

  localparam int CYCLE_LIMIT = 900000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req;
  logic      rsp_valid;
  logic      rsp_stall;
  out_item_t rsp;
  int        mismatches;
  int        pending_results;
  int        results_seen;
  int        cycle_count;
  int        beats_sent;
  bit        calm;

  // Hold the address space to a few sets and tags so lines are reused and evicted.
  logic [26:0] hot_addr[$];

  set_associative_write_back_cache u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  cache_checker u_checker (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .mismatches(mismatches), .pending_results(pending_results),
    .results_seen(results_seen)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Stall the result side at random, except during the calm stretch.
  always @(negedge clk) begin
    rsp_stall <= rst ? 1'b0 : (!calm && $urandom_range(99) < 34);
  end

  // Stop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one beat and hold it until accepted, with a random gap first.
  task automatic send_beat(logic [1:0] k, logic [26:0] a, logic [2:0] c, logic [31:0] d);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 34) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req.kind <= k; req.address <= a; req.byte_count <= c; req.data <= d;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_fill_line();
    for (int i = 0; i < 16; i++) send_beat(IK_FILL, 27'($urandom), 3'($urandom), $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Pick a random legal access, always inside one line.
  task automatic access_random(logic [1:0] k);
    logic [26:0] a;
    logic [2:0]  c;
    c = 3'($urandom_range(1, 4));
    a = hot_addr[$urandom_range(hot_addr.size() - 1)];
    a[5:0] = 6'($urandom_range(0, 64 - c));
    send_beat(k, a, c, $urandom);
  endtask

  initial begin
    logic [26:0] base;
    int r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cycle_count = 0;
    beats_sent = 0;
    calm = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: miss then fill, hits, extremes, errors and ignored fills.
    send_beat(IK_FILL, 27'h0, 3'd4, 32'hdead_beef);
    send_beat(IK_WRITE, 27'h7ff_ffff, 3'd1, 32'hffff_ffff);
    send_beat(IK_READ, 27'h000_0004, 3'd4, 32'h0);
    send_fill_line();
    send_beat(IK_READ, 27'h7ff_ffff, 3'd1, 32'h0);
    send_beat(IK_READ, 27'h7ff_ffc0, 3'd4, 32'h0);
    send_beat(IK_WRITE, 27'h7ff_ffc1, 3'd3, 32'h1234_5678);
    send_beat(IK_BAD, 27'h000_0100, 3'd2, 32'h0);
    send_beat(IK_READ, 27'h000_003e, 3'd4, 32'h0);
    send_beat(IK_READ, 27'h000_0000, 3'd0, 32'h0);
    send_beat(IK_WRITE, 27'h000_0000, 3'd7, 32'h0);
    send_beat(IK_WRITE, 27'h000_0000, 3'd5, 32'h0);
    send_beat(IK_READ, 27'h000_0000, 3'd2, 32'h0);
    send_beat(IK_READ, 27'h000_0010, 3'd1, 32'h0);
    send_fill_line();
    drain();

    // Build a hot pool: two sets, a few more tags than ways, so dirty evictions occur.
    for (int s = 0; s < 2; s++)
      for (int t = 0; t < 20; t++) begin
        base = '0;
        base[17:6] = 12'(s * 7);
        base[26:18] = 9'($urandom);
        hot_addr.push_back(base);
      end

    while (beats_sent < 160) begin
      calm = (beats_sent > 80 && beats_sent < 110);
      r = $urandom_range(99);
      if (r < 45) access_random(IK_WRITE);
      else if (r < 85) access_random(IK_READ);
      else if (r < 90) send_beat(IK_BAD, 27'($urandom), 3'($urandom), $urandom);
      else if (r < 95) send_beat(IK_READ, 27'($urandom), 3'($urandom), $urandom);
      else send_beat(IK_FILL, 27'($urandom), 3'($urandom), $urandom);
      // Most of the time, finish any miss that may be open with a whole line of fill words.
      if ($urandom_range(3) != 0) begin
        send_fill_line();
      end
      if (beats_sent % 300 < 20) drain();
    end
    calm = 1'b0;
    drain();
    $display("sent %0d request beats, checked %0d result beats over %0d cycles",
             beats_sent, results_seen, cycle_count);
    if (mismatches == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
